// ===== rtl/ncpr_pkg.sv =====
// Package for the NVMe controller property register block.
// Holds transaction structs, state struct, offsets, size codes and field codes.
// No dependencies.
package ncpr_pkg;

  localparam logic        OP_GET = 1'b0;
  localparam logic        OP_SET = 1'b1;

  localparam logic [11:0] OFS_CAP  = 12'h000;
  localparam logic [11:0] OFS_VS   = 12'h008;
  localparam logic [11:0] OFS_CC   = 12'h014;
  localparam logic [11:0] OFS_CSTS = 12'h01C;

  localparam logic [2:0]  SIZE_4 = 3'd0;
  localparam logic [2:0]  SIZE_8 = 3'd1;

  localparam logic [1:0]  SHN_NONE     = 2'd0;
  localparam logic [1:0]  SHN_NORMAL   = 2'd1;
  localparam logic [1:0]  SHN_ABRUPT   = 2'd2;
  localparam logic [1:0]  SHST_COMPLETE = 2'd2;

  localparam logic        ST_SUCCESS       = 1'b0;
  localparam logic        ST_INVALID_PARAM = 1'b1;

  localparam logic [31:0] VS_VALUE = 32'h0001_0000;

  localparam int CAP_CQR_BIT = 16;
  localparam int CAP_TO_LSB  = 24;
  localparam int CAP_CSS_BIT = 37;

  localparam logic [15:0] MQES_RESET = 16'd127;

  localparam logic        CFG_IDX_MQES      = 1'b0;
  localparam logic        CFG_IDX_DISCOVERY = 1'b1;

  typedef struct packed {
    logic        op;
    logic [11:0] offset;
    logic [2:0]  size_code;
    logic [63:0] write_value;
  } req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        status;
  } rsp_t;

  typedef struct packed {
    logic       ctrl_enable;
    logic [1:0] shutdown_notify;
    logic [3:0] sq_entry_size_log;
    logic [3:0] cq_entry_size_log;
    logic       ready_flag;
    logic [1:0] shutdown_status;
  } ctrl_state_t;

endpackage

// ===== rtl/ncpr_access.sv =====
// Decode of one property transaction: read mux, CC write checks and next state.
// Depends on ncpr_pkg.
module ncpr_access (
  input  ncpr_pkg::req_t        req,
  input  ncpr_pkg::ctrl_state_t state,
  input  logic [15:0]           mqes,
  input  logic                  discovery,
  output ncpr_pkg::rsp_t        rsp,
  output ncpr_pkg::ctrl_state_t state_nxt
);
  import ncpr_pkg::*;

  logic [63:0] cap_v;
  logic [31:0] cc_v;
  logic [31:0] csts_v;
  logic [31:0] nv;
  logic [31:0] diff;
  logic [1:0]  shn;
  logic        size_ok;
  logic        cc_ok;
  ctrl_state_t wr_state;

  always_comb begin
    cap_v = '0;
    cap_v[15:0] = mqes;
    if (discovery) begin
      cap_v[CAP_CQR_BIT] = 1'b1;
    end else begin
      cap_v[CAP_TO_LSB] = 1'b1;
    end
    cap_v[CAP_CSS_BIT] = 1'b1;

    cc_v = {8'd0, state.cq_entry_size_log, state.sq_entry_size_log,
            state.shutdown_notify, 13'd0, state.ctrl_enable};
    csts_v = {28'd0, state.shutdown_status, 1'b0, state.ready_flag};
  end

  // CC write: fields applied in order, invalid SHN stops before entry sizes
  always_comb begin
    nv       = req.write_value[31:0];
    diff     = nv ^ cc_v;
    shn      = nv[15:14];
    wr_state = state;
    cc_ok    = 1'b1;
    if (diff[0] && nv[0]) begin
      wr_state.ctrl_enable = 1'b1;
      wr_state.ready_flag  = 1'b1;
    end
    if (diff[15:14] != 2'd0 && shn != SHN_NONE && shn != SHN_NORMAL && shn != SHN_ABRUPT) begin
      cc_ok = 1'b0;
    end else begin
      if (diff[15:14] != 2'd0) begin
        wr_state.shutdown_notify = shn;
        if (shn == SHN_NORMAL || shn == SHN_ABRUPT) begin
          wr_state.ctrl_enable     = 1'b0;
          wr_state.ready_flag      = 1'b0;
          wr_state.shutdown_status = SHST_COMPLETE;
        end
      end
      wr_state.sq_entry_size_log = nv[19:16];
      wr_state.cq_entry_size_log = nv[23:20];
      if (nv[13:1] != 13'd0 || nv[31:24] != 8'd0) begin
        cc_ok = 1'b0;
      end
    end
  end

  always_comb begin
    rsp.read_value = '0;
    rsp.status     = ST_SUCCESS;
    state_nxt      = state;
    size_ok        = (req.size_code == SIZE_4) || (req.size_code == SIZE_8);
    if (req.op == OP_GET) begin
      if (!size_ok) begin
        rsp.status = ST_INVALID_PARAM;
      end else begin
        priority case (req.offset)
          OFS_CAP: begin
            if (req.size_code != SIZE_8) rsp.status = ST_INVALID_PARAM;
            else rsp.read_value = cap_v;
          end
          OFS_VS: begin
            if (req.size_code != SIZE_4) rsp.status = ST_INVALID_PARAM;
            else rsp.read_value = {32'd0, VS_VALUE};
          end
          OFS_CC: begin
            if (req.size_code != SIZE_4) rsp.status = ST_INVALID_PARAM;
            else rsp.read_value = {32'd0, cc_v};
          end
          OFS_CSTS: begin
            if (req.size_code != SIZE_4) rsp.status = ST_INVALID_PARAM;
            else rsp.read_value = {32'd0, csts_v};
          end
          default: rsp.read_value = '0;
        endcase
      end
    end else if (req.offset != OFS_CC || req.size_code != SIZE_4) begin
      rsp.status = ST_INVALID_PARAM;
    end else begin
      state_nxt = wr_state;
      if (!cc_ok) rsp.status = ST_INVALID_PARAM;
    end
  end

endmodule

// ===== rtl/nvme_controller_property_registers_core.sv =====
// Top level of the NVMe controller property register block.
// Holds the input stage, result register, CC/CSTS state and config registers.
// Depends on ncpr_pkg and ncpr_access.
//
// One property get or set transaction is taken per clock cycle while the block
// does not stall. A transaction is captured in an input register and decoded in
// the following cycle. Once the result register is free or being read, the
// controller state is updated and the result is loaded into the output register. The
// result register lets a new transaction enter while an earlier result still
// waits. The block stalls only when the input stage and the result register
// are both full and out_ready is low. Configuration writes take effect at
// once and are to be made while no transaction is in flight.
module nvme_controller_property_registers_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ncpr_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ncpr_pkg::rsp_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_wdata
);
  import ncpr_pkg::*;

  req_t        req_r;
  logic        stage_valid_r;
  logic        stage_valid_nxt;
  rsp_t        out_data_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  rsp_t        rsp;
  logic [15:0] mqes_r;
  logic        discovery_r;
  logic        advance;
  logic        fire;
  logic        in_fire;

  assign advance   = !out_valid_r || out_ready;
  assign fire      = stage_valid_r && advance;
  assign in_ready  = !stage_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ncpr_access u_access (
    .req       (req_r),
    .state     (state_r),
    .mqes      (mqes_r),
    .discovery (discovery_r),
    .rsp       (rsp),
    .state_nxt (state_nxt)
  );

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_fire) begin
      stage_valid_nxt = 1'b1;
    end else if (advance) begin
      stage_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r       <= '0;
      mqes_r        <= MQES_RESET;
      discovery_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_MQES:      mqes_r      <= cfg_wdata;
          CFG_IDX_DISCOVERY: discovery_r <= cfg_wdata[0];
          default:           mqes_r      <= mqes_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
    end
    if (fire) begin
      out_data_r <= rsp;
    end
  end

`ifndef SYNTHESIS
  a_ready_tracks_enable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.ready_flag == state_r.ctrl_enable)
    else $error("CSTS.RDY differs from CC.EN");

  a_shst_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.shutdown_status[0] == 1'b0)
    else $error("shutdown status holds an odd code");

  a_shn_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.shutdown_notify != 2'd3)
    else $error("reserved shutdown notification stored");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(fire)) |-> $stable(state_r))
    else $error("controller state changed without a transaction");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_INVALID_PARAM) |-> out_data_r.read_value == 64'd0)
    else $error("failed transaction returned data");
`endif

endmodule

// ===== tb/ncpr_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the NVMe controller property register block: it predicts
// each reply from its own copy of CAP config, CC and CSTS, and checks replies.
// Depends on ncpr_pkg.
package ncpr_tb_pkg;
  import ncpr_pkg::*;

  localparam logic [1:0] SHN_RESERVED = 2'd3;

  class prop_scoreboard;
    ctrl_state_t regs;
    logic [15:0] mqes;
    logic        discovery;
    rsp_t        expected_replies[$];
    int          mismatches;
    int          n_gets;
    int          n_sets;
    int          n_rejected;

    function new();
      regs = '0;
      mqes = MQES_RESET;
      discovery = 1'b0;
      mismatches = 0;
      n_gets = 0;
      n_sets = 0;
      n_rejected = 0;
    endfunction

    function void configure(logic idx, logic [15:0] data);
      if (idx == CFG_IDX_MQES) begin
        mqes = data;
      end else begin
        discovery = data[0];
      end
    endfunction

    function logic [63:0] cap_word();
      logic [63:0] v;
      v = 64'(mqes);
      if (discovery) begin
        v[CAP_CQR_BIT] = 1'b1;
      end else begin
        v[CAP_TO_LSB] = 1'b1;
      end
      v[CAP_CSS_BIT] = 1'b1;
      return v;
    endfunction

    function logic [31:0] cc_word();
      return {8'b0, regs.cq_entry_size_log, regs.sq_entry_size_log,
              regs.shutdown_notify, 13'b0, regs.ctrl_enable};
    endfunction

    function logic [31:0] csts_word();
      return {28'b0, regs.shutdown_status, 1'b0, regs.ready_flag};
    endfunction

    // Apply CC fields in order; earlier updates stay when a later check fails.
    function logic apply_cc(logic [31:0] nv);
      logic [31:0] diff;
      logic [1:0]  shn;
      diff = nv ^ cc_word();
      shn = nv[15:14];
      if (diff[0]) begin
        if (nv[0]) begin
          regs.ctrl_enable = 1'b1;
          regs.ready_flag = 1'b1;
        end
        diff[0] = 1'b0;
      end
      if (diff[15:14] != 2'b0) begin
        if (shn == SHN_NORMAL || shn == SHN_ABRUPT) begin
          regs.shutdown_notify = shn;
          regs.ctrl_enable = 1'b0;
          regs.ready_flag = 1'b0;
          regs.shutdown_status = SHST_COMPLETE;
        end else if (shn == SHN_NONE) begin
          regs.shutdown_notify = SHN_NONE;
        end else begin
          return 1'b0;
        end
        diff[15:14] = 2'b0;
      end
      if (diff[19:16] != 4'b0) begin
        regs.sq_entry_size_log = nv[19:16];
        diff[19:16] = 4'b0;
      end
      if (diff[23:20] != 4'b0) begin
        regs.cq_entry_size_log = nv[23:20];
        diff[23:20] = 4'b0;
      end
      return diff == 32'b0;
    endfunction

    function rsp_t predict_reply(req_t r);
      rsp_t p;
      p.read_value = '0;
      p.status = ST_SUCCESS;
      if (r.op == OP_GET) begin
        if (r.size_code != SIZE_4 && r.size_code != SIZE_8) begin
          p.status = ST_INVALID_PARAM;
        end else begin
          case (r.offset)
            OFS_CAP: begin
              if (r.size_code != SIZE_8) p.status = ST_INVALID_PARAM;
              else p.read_value = cap_word();
            end
            OFS_VS: begin
              if (r.size_code != SIZE_4) p.status = ST_INVALID_PARAM;
              else p.read_value = 64'(VS_VALUE);
            end
            OFS_CC: begin
              if (r.size_code != SIZE_4) p.status = ST_INVALID_PARAM;
              else p.read_value = 64'(cc_word());
            end
            OFS_CSTS: begin
              if (r.size_code != SIZE_4) p.status = ST_INVALID_PARAM;
              else p.read_value = 64'(csts_word());
            end
            default: ;
          endcase
        end
      end else if (r.offset != OFS_CC || r.size_code != SIZE_4) begin
        p.status = ST_INVALID_PARAM;
      end else if (!apply_cc(r.write_value[31:0])) begin
        p.status = ST_INVALID_PARAM;
      end
      return p;
    endfunction

    function void note_access(req_t r);
      rsp_t p;
      p = predict_reply(r);
      if (r.op == OP_GET) n_gets++;
      else n_sets++;
      if (p.status == ST_INVALID_PARAM) n_rejected++;
      expected_replies.push_back(p);
    endfunction

    function void check_reply(rsp_t got);
      rsp_t exp_r;
      if (expected_replies.size() == 0) begin
        $error("reply with no transaction outstanding: read_value %h status %0d",
               got.read_value, got.status);
        mismatches++;
        return;
      end
      exp_r = expected_replies.pop_front();
      if (got.read_value !== exp_r.read_value) begin
        $error("read_value: expected %h, got %h", exp_r.read_value, got.read_value);
        mismatches++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for nvme_controller_property_registers_core: directed
// and random property get/set transactions with random idling on both sides.
// Depends on ncpr_pkg, ncpr_tb_pkg and the block's RTL.
module tb_top;
  import ncpr_pkg::*;
  import ncpr_tb_pkg::*;

  localparam int LIMIT = 500000;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 385;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  rsp_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  prop_scoreboard regs_model = new();
  int cycles = 0;
  int tx_idle_pct = 20;
  int rx_stall_pct = 5;
  int stall_left = 0;
  int settings_used = 1;

  nvme_controller_property_registers_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles,
               regs_model.pending());
      $display("FAIL nvme_controller_property_registers_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) regs_model.check_reply(out_data);
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end else if (rst_n && rx_stall_pct > 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
      stall_left = $urandom_range(1, 16);
      out_ready <= 1'b0;
    end
  end

  function automatic req_t make_access(logic op, logic [11:0] ofs, logic [2:0] sz,
                                       logic [63:0] val);
    req_t r;
    r.op = op;
    r.offset = ofs;
    r.size_code = sz;
    r.write_value = val;
    return r;
  endfunction

  function automatic req_t random_access();
    req_t        r;
    logic [31:0] cc;
    logic [1:0]  shn;
    int          pick;
    int          bit_idx;
    r.write_value = {$urandom(), $urandom()};
    r.op = OP_GET;
    r.offset = OFS_CC;
    r.size_code = SIZE_4;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      cc = regs_model.cc_word();
      r.op = OP_SET;
      if ($urandom_range(0, 2) == 0) cc[0] = ~cc[0];
      case ($urandom_range(0, 9))
        0, 1: shn = SHN_NORMAL;
        2: shn = SHN_ABRUPT;
        3, 4: shn = SHN_NONE;
        5: shn = SHN_RESERVED;
        default: shn = cc[15:14];
      endcase
      cc[15:14] = shn;
      if ($urandom_range(0, 1) == 1) cc[19:16] = 4'($urandom());
      if ($urandom_range(0, 1) == 1) cc[23:20] = 4'($urandom());
      if ($urandom_range(0, 9) == 0) begin
        bit_idx = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 13) : $urandom_range(24, 31);
        cc[bit_idx] = ~cc[bit_idx];
      end
      r.write_value[31:0] = cc;
      if ($urandom_range(0, 19) == 0) r.size_code = SIZE_8;
    end else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0: begin
          r.offset = OFS_CAP;
          r.size_code = SIZE_8;
        end
        1: r.offset = OFS_VS;
        2: r.offset = OFS_CC;
        default: r.offset = OFS_CSTS;
      endcase
      if ($urandom_range(0, 9) == 0) r.size_code = (r.size_code == SIZE_4) ? SIZE_8 : SIZE_4;
    end else begin
      r.op = ($urandom_range(0, 1) == 1) ? OP_SET : OP_GET;
      case ($urandom_range(0, 5))
        0: r.offset = OFS_CAP;
        1: r.offset = OFS_VS;
        2: r.offset = OFS_CC;
        3: r.offset = OFS_CSTS;
        default: r.offset = 12'($urandom_range(0, 4095));
      endcase
      r.size_code = 3'($urandom_range(0, 7));
    end
    return r;
  endfunction

  task automatic send_access(req_t r);
    int gap;
    gap = (tx_idle_pct > 0 && $urandom_range(1, 100) <= tx_idle_pct) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    regs_model.note_access(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (regs_model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_caps(logic [15:0] mqes, logic disc);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_MQES;
    cfg_wdata <= mqes;
    @(posedge clk);
    cfg_index <= CFG_IDX_DISCOVERY;
    cfg_wdata <= {15'b0, disc};
    @(posedge clk);
    cfg_we <= 1'b0;
    regs_model.configure(CFG_IDX_MQES, mqes);
    regs_model.configure(CFG_IDX_DISCOVERY, {15'b0, disc});
    settings_used++;
  endtask

  initial begin
    req_t        directed[$];
    logic [15:0] mqes_set[PHASES];
    logic        disc_set[PHASES];
    int          tx_pct[PHASES];
    int          rx_pct[PHASES];
    int          p;
    int          n;

    mqes_set = '{16'hFFFF, 16'h0000, 16'h0000, 16'h1234, MQES_RESET};
    disc_set = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    mqes_set[2] = 16'($urandom());
    disc_set[2] = 1'($urandom_range(0, 1));
    tx_pct = '{20, 40, 10, 30, 0};
    rx_pct = '{5, 15, 2, 10, 0};

    directed.push_back(make_access(OP_GET, OFS_CAP, SIZE_8, '0));
    directed.push_back(make_access(OP_GET, OFS_CAP, SIZE_4, '1));
    directed.push_back(make_access(OP_GET, OFS_VS, SIZE_4, '0));
    directed.push_back(make_access(OP_GET, OFS_VS, SIZE_8, '0));
    directed.push_back(make_access(OP_GET, OFS_CC, SIZE_4, '0));
    directed.push_back(make_access(OP_GET, OFS_CSTS, SIZE_8, '0));
    directed.push_back(make_access(OP_GET, 12'hFFF, SIZE_4, '1));
    directed.push_back(make_access(OP_GET, OFS_CC, 3'd7, '0));
    directed.push_back(make_access(OP_GET, 12'h010, SIZE_8, '0));
    directed.push_back(make_access(OP_SET, OFS_VS, SIZE_4, 64'h1));
    directed.push_back(make_access(OP_SET, OFS_CC, SIZE_8, 64'h1));
    directed.push_back(make_access(OP_SET, OFS_CC, SIZE_4, 64'hFFFF_FFFF_0000_0001));
    directed.push_back(make_access(OP_GET, OFS_CSTS, SIZE_4, '0));
    directed.push_back(make_access(OP_SET, OFS_CC, SIZE_4, 64'h0));
    directed.push_back(make_access(OP_GET, OFS_CC, SIZE_4, '0));
    directed.push_back(make_access(OP_SET, OFS_CC, SIZE_4, 64'h4001));
    directed.push_back(make_access(OP_GET, OFS_CSTS, SIZE_4, '0));
    directed.push_back(make_access(OP_SET, OFS_CC, SIZE_4, 64'h8000));
    directed.push_back(make_access(OP_SET, OFS_CC, SIZE_4, 64'h0));
    directed.push_back(make_access(OP_SET, OFS_CC, SIZE_4, 64'h00FF_C001));
    directed.push_back(make_access(OP_GET, OFS_CC, SIZE_4, '0));
    directed.push_back(make_access(OP_SET, OFS_CC, SIZE_4, 64'h00A5_0001));
    directed.push_back(make_access(OP_SET, OFS_CC, SIZE_4, 64'h8000_0002));
    directed.push_back(make_access(OP_GET, OFS_CC, SIZE_4, '0));
    directed.push_back(make_access(OP_SET, 12'hFFF, SIZE_4, '1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_access(directed[i]);

    for (p = 0; p < PHASES; p++) begin
      program_caps(mqes_set[p], disc_set[p]);
      tx_idle_pct = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      for (n = 0; n < PHASE_ITEMS; n++) send_access(random_access());
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Checked %0d gets and %0d sets, %0d answered invalid parameter",
             regs_model.n_gets, regs_model.n_sets, regs_model.n_rejected);
    $display("Swept %0d settings of MQES and discovery mode", settings_used);
    if (regs_model.mismatches == 0 && regs_model.pending() == 0) begin
      $display("PASS nvme_controller_property_registers_core");
    end else begin
      $display("FAIL nvme_controller_property_registers_core");
    end
    $finish;
  end

endmodule
